[rtl/uv_sphere_vertex_generator_defines.svh]
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shared macros for the concurrent checks of the vertex generator.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UVS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Widths, register codes, CORDIC constants, shared types and step functions.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int RADIUS_W = 24;
   localparam int COUNT_W  = 9;
   localparam int INDEX_W  = 9;
   localparam int POS_W    = 25;
   localparam int NORM_W   = 16;
   localparam int TEX_W    = 17;
   localparam int QUAD_W   = 17;

   localparam int MAX_RINGS    = 256;
   localparam int MAX_SEGMENTS = 256;
   localparam int MIN_RINGS    = 2;
   localparam int MIN_SEGMENTS = 3;

   localparam logic [RADIUS_W-1:0] RESET_RADIUS   = 24'd65536;
   localparam logic [COUNT_W-1:0]  RESET_SEGMENTS = 9'd64;
   localparam logic [COUNT_W-1:0]  RESET_RINGS    = 9'd32;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENTS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RINGS    = 2'd2;

   localparam int PHASE_W  = 32;
   localparam int TEX_FRAC = 16;

   localparam int DIV_STAGES = 6;
   localparam int DIV_STEPS  = 7;
   localparam int DIV_W      = DIV_STAGES * DIV_STEPS;
   localparam int REM_W      = COUNT_W;
   localparam int DIV_LANES  = 4;
   localparam int LANE_AZ    = 0;
   localparam int LANE_POL   = 1;
   localparam int LANE_TEX_U = 2;
   localparam int LANE_TEX_V = 3;

   localparam int CORDIC_STEPS  = 24;
   localparam int CORDIC_PER    = 3;
   localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;
   localparam int CORDIC_W      = 34;
   localparam int TRIG_W        = 32;
   localparam int ATAN_IDX_W    = $clog2(CORDIC_STEPS);
   localparam int TRIG_LANES    = 2;
   localparam int TRIG_AZ       = 0;
   localparam int TRIG_POL      = 1;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   localparam logic signed [CORDIC_W-1:0] ONE_Q30      = 34'sd1073741824;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

   localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic              point_valid;
      logic              quad_valid;
      logic [QUAD_W-1:0] quad_index_a;
      logic [QUAD_W-1:0] quad_index_b;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } tail_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] num;
   } div_state_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic [1:0]                 quad;
   } cordic_state_type;

   function automatic div_state_type div_steps(input div_state_type s_in,
                                               input logic [COUNT_W-1:0] den);
      div_state_type    s;
      logic [REM_W:0]   t;
      s = s_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
         t = {s.rem, s.num[DIV_W-1]};
         s.num = {s.num[DIV_W-2:0], 1'b0};
         if (t >= {1'b0, den}) begin
            s.rem = REM_W'(t - {1'b0, den});
            s.num[0] = 1'b1;
         end else begin
            s.rem = t[REM_W-1:0];
         end
      end
      return s;
   endfunction

   function automatic cordic_state_type cordic_iters(input cordic_state_type s_in,
                                                     input int base);
      cordic_state_type           s;
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      logic signed [CORDIC_W-1:0] at;
      s = s_in;
      for (int k = 0; k < CORDIC_PER; k++) begin
         dx = $signed(s.y) >>> (base + k);
         dy = $signed(s.x) >>> (base + k);
         at = $signed({{(CORDIC_W-PHASE_W){1'b0}}, ATAN_TURNS[ATAN_IDX_W'(base + k)]});
         if (!s.z[CORDIC_W-1]) begin
            s.x = $signed(s.x) - dx;
            s.y = $signed(s.y) + dy;
            s.z = $signed(s.z) - at;
         end else begin
            s.x = $signed(s.x) + dx;
            s.y = $signed(s.y) - dy;
            s.z = $signed(s.z) + at;
         end
      end
      return s;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] c;
      if (v < -ONE_Q30) begin
         c = -ONE_Q30;
      end else if (v > ONE_Q30) begin
         c = ONE_Q30;
      end else begin
         c = v;
      end
      return c[TRIG_W-1:0];
   endfunction

endpackage

[rtl/uvs_if.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator channels
// Valid/ready interfaces for the grid point requests and the vertex responses.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   logic                        valid;
   logic                        ready;
   logic [uvs_pkg::INDEX_W-1:0] ring_index;
   logic [uvs_pkg::INDEX_W-1:0] segment_index;

   modport source (output valid, ring_index, segment_index, input ready);
   modport sink (input valid, ring_index, segment_index, output ready);
   modport monitor (input valid, ready, ring_index, segment_index);
endinterface

interface uvs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [uvs_pkg::POS_W-1:0]  pos_x;
   logic signed [uvs_pkg::POS_W-1:0]  pos_y;
   logic signed [uvs_pkg::POS_W-1:0]  pos_z;
   logic signed [uvs_pkg::NORM_W-1:0] norm_x;
   logic signed [uvs_pkg::NORM_W-1:0] norm_y;
   logic signed [uvs_pkg::NORM_W-1:0] norm_z;
   logic [uvs_pkg::TEX_W-1:0]         tex_u;
   logic [uvs_pkg::TEX_W-1:0]         tex_v;
   logic [uvs_pkg::QUAD_W-1:0]        quad_index_a;
   logic [uvs_pkg::QUAD_W-1:0]        quad_index_b;
   logic                              quad_valid;
   logic                              point_valid;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, quad_index_a, quad_index_b, quad_valid,
                   point_valid, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 tex_u, tex_v, quad_index_a, quad_index_b, quad_valid,
                 point_valid, output ready);
   modport monitor (input valid, ready, pos_x, pos_y, pos_z, norm_x, norm_y,
                    norm_z, tex_u, tex_v, quad_index_a, quad_index_b,
                    quad_valid, point_valid);
endinterface

[rtl/uvs_phase.sv]
// ----------------------------------------------------------------------------
// UV sphere phase divider
// Pipelined long division giving the azimuth and polar phases and the
// texture coordinates of a grid point, several quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_phase
   import uvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [INDEX_W-1:0]    in_ring,
   input  logic [INDEX_W-1:0]    in_seg,
   input  meta_type              in_meta,
   input  logic [COUNT_W-1:0]    segs,
   input  logic [COUNT_W-1:0]    rings,
   output logic                  out_valid,
   output logic [PHASE_W-1:0]    out_az,
   output logic [PHASE_W-1:0]    out_pol,
   output tail_type              out_tail
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   meta_type              meta_ff [DIV_STAGES];
   meta_type              meta_in [DIV_STAGES];
   div_state_type         st_ff [DIV_STAGES][DIV_LANES];
   div_state_type         st_in [DIV_STAGES][DIV_LANES];
   div_state_type         init [DIV_LANES];
   div_state_type         src;
   logic [COUNT_W-1:0]    den;

   always_comb begin
      init[LANE_AZ].rem    = '0;
      init[LANE_AZ].num    = (DIV_W'(in_seg) << PHASE_W) + DIV_W'(segs >> 1);
      init[LANE_POL].rem   = '0;
      init[LANE_POL].num   = (DIV_W'(in_ring) << (PHASE_W - 1)) + DIV_W'(rings >> 1);
      init[LANE_TEX_U].rem = '0;
      init[LANE_TEX_U].num = (DIV_W'(in_seg) << TEX_FRAC) + DIV_W'(segs >> 1);
      init[LANE_TEX_V].rem = '0;
      init[LANE_TEX_V].num = (DIV_W'(in_ring) << TEX_FRAC) + DIV_W'(rings >> 1);
      src = '0;
      den = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            src = (s == 0) ? init[l] : st_ff[(s == 0) ? 0 : s - 1][l];
            den = (l == LANE_AZ || l == LANE_TEX_U) ? segs : rings;
            st_in[s][l] = div_steps(src, den);
         end
         if (s == 0) begin
            valid_in[s] = in_valid;
            meta_in[s]  = in_meta;
         end else begin
            valid_in[s] = valid_ff[s - 1];
            meta_in[s]  = meta_ff[s - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid      = valid_ff[DIV_STAGES-1];
   assign out_az         = st_ff[DIV_STAGES-1][LANE_AZ].num[PHASE_W-1:0];
   assign out_pol        = st_ff[DIV_STAGES-1][LANE_POL].num[PHASE_W-1:0];
   assign out_tail.meta  = meta_ff[DIV_STAGES-1];
   assign out_tail.tex_u = st_ff[DIV_STAGES-1][LANE_TEX_U].num[TEX_W-1:0];
   assign out_tail.tex_v = st_ff[DIV_STAGES-1][LANE_TEX_V].num[TEX_W-1:0];

endmodule

[rtl/uvs_cordic.sv]
// ----------------------------------------------------------------------------
// UV sphere CORDIC pipeline
// Cosine and sine of the azimuth and polar phases by a pipelined rotation
// CORDIC, followed by clamping and quadrant restoration.
// ----------------------------------------------------------------------------
module uvs_cordic
   import uvs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [PHASE_W-1:0]       in_az,
   input  logic [PHASE_W-1:0]       in_pol,
   input  tail_type                 in_tail,
   output logic                     out_valid,
   output logic signed [TRIG_W-1:0] out_cp,
   output logic signed [TRIG_W-1:0] out_sp,
   output logic signed [TRIG_W-1:0] out_ct,
   output logic signed [TRIG_W-1:0] out_st,
   output tail_type                 out_tail
);

   logic [CORDIC_STAGES-1:0] valid_ff;
   logic [CORDIC_STAGES-1:0] valid_in;
   tail_type                 tail_ff [CORDIC_STAGES];
   tail_type                 tail_in [CORDIC_STAGES];
   cordic_state_type         st_ff [CORDIC_STAGES][TRIG_LANES];
   cordic_state_type         st_in [CORDIC_STAGES][TRIG_LANES];
   cordic_state_type         init [TRIG_LANES];
   logic [PHASE_W-1:0]       phase [TRIG_LANES];
   logic signed [TRIG_W-1:0] cx;
   logic signed [TRIG_W-1:0] cy;
   logic signed [TRIG_W-1:0] cos_in [TRIG_LANES];
   logic signed [TRIG_W-1:0] sin_in [TRIG_LANES];
   logic signed [TRIG_W-1:0] cos_ff [TRIG_LANES];
   logic signed [TRIG_W-1:0] sin_ff [TRIG_LANES];
   logic                     last_valid_ff;
   tail_type                 last_tail_ff;

   always_comb begin
      phase[TRIG_AZ]  = in_az;
      phase[TRIG_POL] = in_pol;
      for (int l = 0; l < TRIG_LANES; l++) begin
         init[l].x    = CORDIC_START;
         init[l].y    = '0;
         init[l].z    = $signed({{(CORDIC_W-PHASE_W+2){1'b0}}, phase[l][PHASE_W-3:0]});
         init[l].quad = phase[l][PHASE_W-1:PHASE_W-2];
      end
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         for (int l = 0; l < TRIG_LANES; l++) begin
            if (s == 0) begin
               st_in[s][l] = cordic_iters(init[l], 0);
            end else begin
               st_in[s][l] = cordic_iters(st_ff[s - 1][l], s * CORDIC_PER);
            end
         end
         if (s == 0) begin
            valid_in[s] = in_valid;
            tail_in[s]  = in_tail;
         end else begin
            valid_in[s] = valid_ff[s - 1];
            tail_in[s]  = tail_ff[s - 1];
         end
      end
      cx = '0;
      cy = '0;
      for (int l = 0; l < TRIG_LANES; l++) begin
         cx = clamp_q30(st_ff[CORDIC_STAGES-1][l].x);
         cy = clamp_q30(st_ff[CORDIC_STAGES-1][l].y);
         case (st_ff[CORDIC_STAGES-1][l].quad)
            QUAD_I: begin
               cos_in[l] = cx;
               sin_in[l] = cy;
            end
            QUAD_II: begin
               cos_in[l] = -cy;
               sin_in[l] = cx;
            end
            QUAD_III: begin
               cos_in[l] = -cx;
               sin_in[l] = -cy;
            end
            default: begin
               cos_in[l] = cy;
               sin_in[l] = -cx;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         last_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff      <= valid_in;
         last_valid_ff <= valid_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff        <= st_in;
         tail_ff      <= tail_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         last_tail_ff <= tail_ff[CORDIC_STAGES-1];
      end
   end

   assign out_valid = last_valid_ff;
   assign out_cp    = cos_ff[TRIG_AZ];
   assign out_sp    = sin_ff[TRIG_AZ];
   assign out_ct    = cos_ff[TRIG_POL];
   assign out_st    = sin_ff[TRIG_POL];
   assign out_tail  = last_tail_ff;

endmodule

[rtl/uvs_scale.sv]
// ----------------------------------------------------------------------------
// UV sphere normal and position scaling
// Forms the unit normal from the sines and cosines, scales it by the radius
// and rounds both to their output formats.
// ----------------------------------------------------------------------------
module uvs_scale
   import uvs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic [RADIUS_W-1:0]      radius,
   input  logic                     in_valid,
   input  logic signed [TRIG_W-1:0] in_cp,
   input  logic signed [TRIG_W-1:0] in_sp,
   input  logic signed [TRIG_W-1:0] in_ct,
   input  logic signed [TRIG_W-1:0] in_st,
   input  tail_type                 in_tail,
   output logic                     out_valid,
   output logic signed [POS_W-1:0]  out_pos [3],
   output logic signed [NORM_W-1:0] out_norm [3],
   output tail_type                 out_tail
);

   localparam int PROD_W = 2 * TRIG_W;
   localparam int PPOS_W = RADIUS_W + 1 + TRIG_W;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   function automatic logic signed [TRIG_W-1:0] round_norm(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      logic signed [PROD_W-1:0] c;
      t = (p + (PROD_W'(1) <<< 29)) >>> 30;
      if (t < PROD_W'(-ONE_Q30)) begin
         c = PROD_W'(-ONE_Q30);
      end else if (t > PROD_W'(ONE_Q30)) begin
         c = PROD_W'(ONE_Q30);
      end else begin
         c = t;
      end
      return c[TRIG_W-1:0];
   endfunction

   function automatic logic signed [NORM_W-1:0] round_q214(input logic signed [TRIG_W-1:0] n);
      logic signed [TRIG_W:0] t;
      logic signed [TRIG_W:0] c;
      t = ($signed({n[TRIG_W-1], n}) + (TRIG_W + 1)'(32768)) >>> 16;
      if (t < -(TRIG_W + 1)'(16384)) begin
         c = -(TRIG_W + 1)'(16384);
      end else if (t > (TRIG_W + 1)'(16384)) begin
         c = (TRIG_W + 1)'(16384);
      end else begin
         c = t;
      end
      return c[NORM_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] round_pos(input logic signed [PPOS_W-1:0] p);
      logic signed [PPOS_W-1:0] t;
      logic signed [PPOS_W-1:0] c;
      t = (p + (PPOS_W'(1) <<< 29)) >>> 30;
      if (t < -(PPOS_W'(1) <<< (POS_W - 1))) begin
         c = -(PPOS_W'(1) <<< (POS_W - 1));
      end else if (t > (PPOS_W'(1) <<< (POS_W - 1)) - PPOS_W'(1)) begin
         c = (PPOS_W'(1) <<< (POS_W - 1)) - PPOS_W'(1);
      end else begin
         c = t;
      end
      return c[POS_W-1:0];
   endfunction

   logic [2:0]               valid_ff;
   tail_type                 tail_a_ff;
   tail_type                 tail_b_ff;
   tail_type                 tail_c_ff;
   logic signed [PROD_W-1:0] px_ff;
   logic signed [PROD_W-1:0] pz_ff;
   logic signed [TRIG_W-1:0] ny_a_ff;
   logic signed [TRIG_W-1:0] n_ff [3];
   logic signed [TRIG_W-1:0] n_in [3];
   logic signed [PPOS_W-1:0] pr_ff [3];
   logic signed [PPOS_W-1:0] pr_in [3];
   logic signed [NORM_W-1:0] nq_ff [3];
   logic signed [NORM_W-1:0] nq_in [3];

   always_comb begin
      n_in[AXIS_X] = round_norm(px_ff);
      n_in[AXIS_Y] = ny_a_ff;
      n_in[AXIS_Z] = round_norm(pz_ff);
      for (int k = 0; k < 3; k++) begin
         pr_in[k] = $signed({1'b0, radius}) * n_ff[k];
         nq_in[k] = round_q214(n_ff[k]);
         out_pos[k]  = round_pos(pr_ff[k]);
         out_norm[k] = nq_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff     <= in_cp * in_st;
         pz_ff     <= in_sp * in_st;
         ny_a_ff   <= in_ct;
         tail_a_ff <= in_tail;
         n_ff      <= n_in;
         tail_b_ff <= tail_a_ff;
         pr_ff     <= pr_in;
         nq_ff     <= nq_in;
         tail_c_ff <= tail_b_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_tail  = tail_c_ff;

endmodule

[rtl/uv_sphere_vertex_generator.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Turns one grid point of a UV sphere into its vertex position, unit normal,
// texture coordinate and quad indices.
// ----------------------------------------------------------------------------
// The request channel carries a ring index and a segment index; the response
// channel carries one result item for every request item, in order.
// The registers (radius, segment count, ring count) are written through the
// csr port and may only change while no item is in flight.
// From acceptance to a valid response an item passes six divider stages
// for the phases and texture coordinates, eight CORDIC stages plus one
// quadrant stage, three multiply and rounding stages and the output register.
// Throughput is one item per cycle while no response is stalled. The whole
// pipeline advances together, so a stalled response holds every stage and
// req_ch.ready stays low until the output register is emptied.
// Synchronous reset clears all valid bits and loads the register defaults:
// radius 1.0, 64 segments and 32 rings. There is no clearing pass after reset.
// Points beyond the configured counts come back with point_valid low and all
// other fields zero.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
   import uvs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   uvs_req_if.sink                req_ch,
   uvs_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RADIUS_W-1:0]    csr_wdata
);

   logic [RADIUS_W-1:0] radius_ff;
   logic [COUNT_W-1:0]  segs_ff;
   logic [COUNT_W-1:0]  rings_ff;
   logic [COUNT_W-1:0]  segs_wr;
   logic [COUNT_W-1:0]  rings_wr;
   logic                adv;
   logic [COUNT_W:0]    segs_p1;
   logic [18:0]         quad_full;
   meta_type            meta;

   logic                     ph_valid;
   logic [PHASE_W-1:0]       ph_az;
   logic [PHASE_W-1:0]       ph_pol;
   tail_type                 ph_tail;
   logic                     cd_valid;
   logic signed [TRIG_W-1:0] cd_cp;
   logic signed [TRIG_W-1:0] cd_sp;
   logic signed [TRIG_W-1:0] cd_ct;
   logic signed [TRIG_W-1:0] cd_st;
   tail_type                 cd_tail;
   logic                     sc_valid;
   logic signed [POS_W-1:0]  sc_pos [3];
   logic signed [NORM_W-1:0] sc_norm [3];
   tail_type                 sc_tail;

   logic                     rsp_valid_ff;
   logic signed [POS_W-1:0]  pos_x_ff;
   logic signed [POS_W-1:0]  pos_y_ff;
   logic signed [POS_W-1:0]  pos_z_ff;
   logic signed [NORM_W-1:0] norm_x_ff;
   logic signed [NORM_W-1:0] norm_y_ff;
   logic signed [NORM_W-1:0] norm_z_ff;
   logic [TEX_W-1:0]         tex_u_ff;
   logic [TEX_W-1:0]         tex_v_ff;
   logic [QUAD_W-1:0]        quad_a_ff;
   logic [QUAD_W-1:0]        quad_b_ff;
   logic                     quad_valid_ff;
   logic                     point_valid_ff;

   always_comb begin
      segs_wr = csr_wdata[COUNT_W-1:0];
      if (segs_wr < COUNT_W'(MIN_SEGMENTS)) begin
         segs_wr = COUNT_W'(MIN_SEGMENTS);
      end else if (segs_wr > COUNT_W'(MAX_SEGMENTS)) begin
         segs_wr = COUNT_W'(MAX_SEGMENTS);
      end
      rings_wr = csr_wdata[COUNT_W-1:0];
      if (rings_wr < COUNT_W'(MIN_RINGS)) begin
         rings_wr = COUNT_W'(MIN_RINGS);
      end else if (rings_wr > COUNT_W'(MAX_RINGS)) begin
         rings_wr = COUNT_W'(MAX_RINGS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RESET_RADIUS;
         segs_ff   <= RESET_SEGMENTS;
         rings_ff  <= RESET_RINGS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_wdata;
            CSR_SEGMENTS: segs_ff   <= segs_wr;
            CSR_RINGS:    rings_ff  <= rings_wr;
            default: begin
            end
         endcase
      end
   end

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      segs_p1   = {1'b0, segs_ff} + (COUNT_W + 1)'(1);
      quad_full = 19'(req_ch.ring_index) * 19'(segs_p1) + 19'(req_ch.segment_index);
      meta.point_valid  = (req_ch.ring_index <= rings_ff) &&
                          (req_ch.segment_index <= segs_ff);
      meta.quad_valid   = (req_ch.ring_index < rings_ff) &&
                          (req_ch.segment_index < segs_ff);
      meta.quad_index_a = quad_full[QUAD_W-1:0];
      meta.quad_index_b = meta.quad_valid ?
                          QUAD_W'(quad_full + 19'(segs_p1)) : '0;
   end

   uvs_phase u_phase (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_ch.valid),
      .in_ring  (req_ch.ring_index),
      .in_seg   (req_ch.segment_index),
      .in_meta  (meta),
      .segs     (segs_ff),
      .rings    (rings_ff),
      .out_valid(ph_valid),
      .out_az   (ph_az),
      .out_pol  (ph_pol),
      .out_tail (ph_tail)
   );

   uvs_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (ph_valid),
      .in_az    (ph_az),
      .in_pol   (ph_pol),
      .in_tail  (ph_tail),
      .out_valid(cd_valid),
      .out_cp   (cd_cp),
      .out_sp   (cd_sp),
      .out_ct   (cd_ct),
      .out_st   (cd_st),
      .out_tail (cd_tail)
   );

   uvs_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .radius   (radius_ff),
      .in_valid (cd_valid),
      .in_cp    (cd_cp),
      .in_sp    (cd_sp),
      .in_ct    (cd_ct),
      .in_st    (cd_st),
      .in_tail  (cd_tail),
      .out_valid(sc_valid),
      .out_pos  (sc_pos),
      .out_norm (sc_norm),
      .out_tail (sc_tail)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sc_tail.meta.point_valid) begin
            pos_x_ff      <= sc_pos[0];
            pos_y_ff      <= sc_pos[1];
            pos_z_ff      <= sc_pos[2];
            norm_x_ff     <= sc_norm[0];
            norm_y_ff     <= sc_norm[1];
            norm_z_ff     <= sc_norm[2];
            tex_u_ff      <= sc_tail.tex_u;
            tex_v_ff      <= sc_tail.tex_v;
            quad_a_ff     <= sc_tail.meta.quad_index_a;
            quad_b_ff     <= sc_tail.meta.quad_index_b;
            quad_valid_ff <= sc_tail.meta.quad_valid;
         end else begin
            pos_x_ff      <= '0;
            pos_y_ff      <= '0;
            pos_z_ff      <= '0;
            norm_x_ff     <= '0;
            norm_y_ff     <= '0;
            norm_z_ff     <= '0;
            tex_u_ff      <= '0;
            tex_v_ff      <= '0;
            quad_a_ff     <= '0;
            quad_b_ff     <= '0;
            quad_valid_ff <= 1'b0;
         end
         point_valid_ff <= sc_tail.meta.point_valid;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pos_x        = pos_x_ff;
   assign rsp_ch.pos_y        = pos_y_ff;
   assign rsp_ch.pos_z        = pos_z_ff;
   assign rsp_ch.norm_x       = norm_x_ff;
   assign rsp_ch.norm_y       = norm_y_ff;
   assign rsp_ch.norm_z       = norm_z_ff;
   assign rsp_ch.tex_u        = tex_u_ff;
   assign rsp_ch.tex_v        = tex_v_ff;
   assign rsp_ch.quad_index_a = quad_a_ff;
   assign rsp_ch.quad_index_b = quad_b_ff;
   assign rsp_ch.quad_valid   = quad_valid_ff;
   assign rsp_ch.point_valid  = point_valid_ff;

endmodule

[rtl/uvs_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator checker
// Port-level checks on the response channel and its coupling to requests.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_defines.svh"

module uvs_checker (
   input logic       clock,
   input logic       reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch
);

   `UVS_ASSERT_NEXT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid && $stable(rsp_ch.pos_x) && $stable(rsp_ch.quad_index_a) && $stable(rsp_ch.tex_u), "stalled response item changed")

   `UVS_ASSERT_SAME(a_stall_blocks_req, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "request taken while response stalled")

   `UVS_ASSERT_SAME(a_invalid_zero, rsp_ch.valid && !rsp_ch.point_valid, rsp_ch.pos_x == 0 && rsp_ch.norm_y == 0 && rsp_ch.tex_v == 0 && rsp_ch.quad_index_a == 0 && !rsp_ch.quad_valid, "out-of-range item has nonzero fields")

   `UVS_ASSERT_SAME(a_quad_consistent, rsp_ch.valid, (!rsp_ch.quad_valid || rsp_ch.point_valid) && (rsp_ch.quad_valid || rsp_ch.quad_index_b == 0), "quad fields inconsistent")

   `UVS_ASSERT_SAME(a_norm_range, rsp_ch.valid, rsp_ch.norm_x <= 16384 && rsp_ch.norm_x >= -16384 && rsp_ch.norm_y <= 16384 && rsp_ch.norm_y >= -16384 && rsp_ch.norm_z <= 16384 && rsp_ch.norm_z >= -16384, "normal out of range")

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
   .clock (clock),
   .reset (reset),
   .req_ch(req_ch),
   .rsp_ch(rsp_ch)
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Drives grid point items through the request channel under several idling
// phases and register settings, predicts vertex results with an independent
// fixed point model or fixed vectors and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_top
   import uvs_pkg::*;
;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      logic [TEX_W-1:0]         tex_u;
      logic [TEX_W-1:0]         tex_v;
      logic [QUAD_W-1:0]        quad_index_a;
      logic [QUAD_W-1:0]        quad_index_b;
      logic                     quad_valid;
      logic                     point_valid;
   } vertex_type;

   typedef struct {
      logic [INDEX_W-1:0] ring;
      logic [INDEX_W-1:0] seg;
      bit                 typed;
      vertex_type         vtx;
   } point_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [RADIUS_W-1:0] csr_wdata = '0;

   uvs_req_if req_ch ();
   uvs_rsp_if rsp_ch ();

   uv_sphere_vertex_generator u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   longint unsigned radius_q = 65536;
   longint unsigned segs_q = 64;
   longint unsigned rings_q = 32;

   vertex_type pending_vertices[$];
   int sent_items = 0;
   int got_items = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.ring_index = '0;
      req_ch.segment_index = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic longint asr_q(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
      longint x, y, z, dx, dy, one;
      logic [1:0] quad;
      one = 64'sd1073741824;
      quad = phase[31:30];
      z = longint'(phase[29:0]);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = asr_q(y, i);
         dy = asr_q(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
         end
      end
      x = clip(x, -one, one);
      y = clip(y, -one, one);
      case (quad)
         QUAD_I:   begin c = x;  s = y;  end
         QUAD_II:  begin c = -y; s = x;  end
         QUAD_III: begin c = -x; s = -y; end
         default:  begin c = y;  s = -x; end
      endcase
   endtask

   task automatic predict_vertex(input logic [INDEX_W-1:0] ring_in,
                                 input logic [INDEX_W-1:0] seg_in, output vertex_type v);
      longint unsigned ring, seg, a;
      longint cp, sp, ct, st, one;
      longint n[3];
      longint p[3];
      longint q[3];
      logic [31:0] az, pol;
      ring = ring_in;
      seg = seg_in;
      one = 64'sd1073741824;
      v = '0;
      if (ring > rings_q || seg > segs_q) return;
      az = 32'(((seg << 32) + segs_q / 2) / segs_q);
      pol = 32'(((ring << 31) + rings_q / 2) / rings_q);
      sin_cos(az, cp, sp);
      sin_cos(pol, ct, st);
      n[0] = clip(round_shift(cp * st, 30), -one, one);
      n[1] = ct;
      n[2] = clip(round_shift(sp * st, 30), -one, one);
      for (int k = 0; k < 3; k++) begin
         p[k] = clip(round_shift(longint'(radius_q) * n[k], 30), -16777216, 16777215);
         q[k] = clip(round_shift(n[k], 16), -16384, 16384);
      end
      v.pos_x = POS_W'(p[0]);
      v.pos_y = POS_W'(p[1]);
      v.pos_z = POS_W'(p[2]);
      v.norm_x = NORM_W'(q[0]);
      v.norm_y = NORM_W'(q[1]);
      v.norm_z = NORM_W'(q[2]);
      v.tex_u = TEX_W'(((seg << 16) + segs_q / 2) / segs_q);
      v.tex_v = TEX_W'(((ring << 16) + rings_q / 2) / rings_q);
      a = ring * (segs_q + 1) + seg;
      v.quad_index_a = QUAD_W'(a);
      if (ring < rings_q && seg < segs_q) begin
         v.quad_index_b = QUAD_W'(a + segs_q + 1);
         v.quad_valid = 1'b1;
      end
      v.point_valid = 1'b1;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [RADIUS_W-1:0] val);
      longint unsigned c;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      c = val[COUNT_W-1:0];
      case (idx)
         CSR_RADIUS: radius_q = val;
         CSR_SEGMENTS: radius_q = radius_q;
         default: ;
      endcase
      if (idx == CSR_SEGMENTS) segs_q = c < MIN_SEGMENTS ? MIN_SEGMENTS :
                                        (c > MAX_SEGMENTS ? MAX_SEGMENTS : c);
      if (idx == CSR_RINGS) rings_q = c < MIN_RINGS ? MIN_RINGS :
                                      (c > MAX_RINGS ? MAX_RINGS : c);
   endtask

   task automatic drain_pipeline();
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_point(input logic [INDEX_W-1:0] ring, input logic [INDEX_W-1:0] seg,
                             input bit typed, input vertex_type typed_vtx);
      vertex_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ring_index <= ring;
      req_ch.segment_index <= seg;
      do @(posedge clock); while (!req_ch.ready);
      if (typed) v = typed_vtx;
      else predict_vertex(ring, seg, v);
      pending_vertices.insert(pending_vertices.size(), v);
      sent_items++;
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_burst(input int count);
      logic [INDEX_W-1:0] r, s;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8) begin
            r = INDEX_W'($urandom_range(int'(rings_q)));
            s = INDEX_W'($urandom_range(int'(segs_q)));
         end else begin
            r = INDEX_W'($urandom);
            s = INDEX_W'($urandom);
         end
         send_point(r, s, 1'b0, '0);
      end
      stop_sending();
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      vertex_type act, exp_v;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act = '{rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z, rsp_ch.norm_x,
                 rsp_ch.norm_y, rsp_ch.norm_z, rsp_ch.tex_u, rsp_ch.tex_v,
                 rsp_ch.quad_index_a, rsp_ch.quad_index_b, rsp_ch.quad_valid,
                 rsp_ch.point_valid};
         got_items++;
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected vertex item %p", act);
         end else begin
            exp_v = pending_vertices.pop_front();
            if (act !== exp_v) begin
               mismatches++;
               if (mismatches <= 10) $display("vertex mismatch\n  exp %p\n  got %p", exp_v, act);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d items outstanding", pending_vertices.size());
         $display("** uv_sphere_vertex_generator: FAILED **");
         $finish;
      end
   end

   point_row_type rows[$];

   initial begin
      vertex_type v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the top pole is a known vector with radius 1.0.
      v = '0;
      v.pos_y = 25'sd65536; v.norm_y = 16'sd16384; v.quad_index_b = 17'd65;
      v.quad_valid = 1'b1; v.point_valid = 1'b1;
      rows.insert(rows.size(), point_row_type'{9'd0, 9'd0, 1'b1, v});
      rows.insert(rows.size(), point_row_type'{9'd33, 9'd0, 1'b1, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd0, 9'd65, 1'b1, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd511, 9'd511, 1'b1, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd32, 9'd64, 1'b0, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd16, 9'd16, 1'b0, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd8, 9'd48, 1'b0, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd31, 9'd63, 1'b0, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd32, 9'd0, 1'b0, vertex_type'('0)});
      rows.insert(rows.size(), point_row_type'{9'd0, 9'd64, 1'b0, vertex_type'('0)});
      foreach (rows[i]) send_point(rows[i].ring, rows[i].seg, rows[i].typed, rows[i].vtx);
      stop_sending();
      drain_pipeline();

      // Clamped small writes to the minimum counts, zero radius and an unmapped write.
      write_reg(CSR_SEGMENTS, 24'd0);
      write_reg(CSR_RINGS, 24'd1);
      write_reg(CSR_RADIUS, 24'd0);
      write_reg(CSR_UNMAPPED, 24'hFFFFFF);
      for (int r = 0; r < 4; r++)
         for (int s = 0; s < 5; s++) send_point(INDEX_W'(r), INDEX_W'(s), 1'b0, '0);
      stop_sending();
      drain_pipeline();

      // Maximum radius and counts, including writes above the maximum.
      write_reg(CSR_RADIUS, 24'hFFFFFF);
      write_reg(CSR_SEGMENTS, 24'h1FF);
      write_reg(CSR_RINGS, 24'd511);
      send_point(9'd256, 9'd256, 1'b0, '0);
      send_point(9'd128, 9'd64, 1'b0, '0);
      send_point(9'd255, 9'd255, 1'b0, '0);
      send_point(9'd257, 9'd0, 1'b0, '0);
      stop_sending();
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         write_reg(CSR_RADIUS, RADIUS_W'($urandom));
         write_reg(CSR_SEGMENTS, ($urandom_range(3) == 0) ? 24'($urandom_range(511))
                                                           : 24'($urandom_range(3, 40)));
         write_reg(CSR_RINGS, ($urandom_range(3) == 0) ? 24'($urandom_range(511))
                                                        : 24'($urandom_range(2, 40)));
         if (phase == 0) hold_off <= 300;
         random_burst(95);
         drain_pipeline();
      end

      $display("Covered %0d items over reset, minimum, maximum and random settings,", sent_items);
      $display("with sender idling, receiver stalls and a long receiver hold-off.");
      if (mismatches == 0 && pending_vertices.size() == 0 && got_items == sent_items) begin
         $display("** uv_sphere_vertex_generator: PASSED **");
      end else begin
         $display("%0d mismatches, %0d items left", mismatches, pending_vertices.size());
         $display("** uv_sphere_vertex_generator: FAILED **");
      end
      $finish;
   end
endmodule
